>>> rtl/core/cuaf_pkg.sv
// cuaf_pkg: shared types and constants of the centroid update pipeline
// depends on nothing; used by every module of the block
package cuaf_pkg;

  localparam int unsigned DIM_W    = 11;
  localparam int unsigned PT_W     = 10;
  localparam int unsigned VOL_W    = 20;
  localparam int unsigned SUM_W    = 30;
  localparam int unsigned CM_W     = 20;
  localparam int unsigned FRAC     = 8;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [DIM_W-1:0] DIM_MAX   = 11'd1024;
  localparam logic [DIM_W-1:0] DIM_RESET = 11'd256;
  localparam logic [DIM_W-1:0] DIMZ_RESET = 11'd1;

  // quotient bits of the shift divider (saturates above) and of the result divider
  localparam int unsigned Q1_W = 12;
  localparam int unsigned Q2_W = 20;

  // stage map
  localparam int unsigned ST_C    = Q1_W + 1;
  localparam int unsigned ST_MUL  = ST_C + 1;
  localparam int unsigned ST_WRAP = ST_MUL + 1;
  localparam int unsigned ST_N    = ST_WRAP + 1;
  localparam int unsigned ST_OUT  = ST_N + Q2_W + 1;
  localparam int unsigned NSTAGE  = ST_OUT + 1;

  localparam logic signed [CM_W-1:0] OUT_LO = -20'sd262144;
  localparam logic signed [CM_W-1:0] OUT_HI = 20'sd262400;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DIM_X  = 3'd0,
    REG_DIM_Y  = 3'd1,
    REG_DIM_Z  = 3'd2,
    REG_PER_X  = 3'd3,
    REG_PER_Y  = 3'd4,
    REG_PER_Z  = 3'd5
  } cuaf_reg_e;

  typedef struct packed {
    logic             operation;
    logic [PT_W-1:0]  pt_x;
    logic [PT_W-1:0]  pt_y;
    logic [PT_W-1:0]  pt_z;
    logic [VOL_W-1:0] volume;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [SUM_W-1:0] sum_z;
  } cuaf_in_t;

  typedef struct packed {
    logic signed [CM_W-1:0] cm_x;
    logic signed [CM_W-1:0] cm_y;
    logic signed [CM_W-1:0] cm_z;
  } cuaf_out_t;

  // shift divider stage: sum / volume
  typedef struct packed {
    logic             lose;
    logic             raw;
    logic [PT_W-1:0]  pt;
    logic [VOL_W-1:0] vol;
    logic [SUM_W-1:0] sum;
    logic             sat;
    logic [VOL_W-1:0] rem;
    logic [Q1_W-1:0]  quo;
  } cuaf_d1_t;

  typedef struct packed {
    logic                   raw;
    logic [CM_W-1:0]        rawval;
    logic signed [31:0]     c;
    logic [VOL_W:0]         n;
    logic [30:0]            dn;
  } cuaf_mid_t;

  // result divider stage: |512c + n| / 2n
  typedef struct packed {
    logic             raw;
    logic [CM_W-1:0]  rawval;
    logic             neg;
    logic             sat;
    logic [VOL_W+1:0] d;
    logic [40:0]      mag;
    logic [VOL_W+1:0] rem;
    logic [Q2_W-1:0]  quo;
  } cuaf_d2_t;

endpackage

>>> rtl/core/cuaf_axis.sv
// cuaf_axis: one axis of the centroid pipeline, two restoring dividers
// depends on cuaf_pkg; stage enables come from the top level
module cuaf_axis (
  input  logic                             clk_i,
  input  logic [cuaf_pkg::NSTAGE-1:0]      en_i,
  input  logic                             lose_i,
  input  logic [cuaf_pkg::PT_W-1:0]        pt_i,
  input  logic [cuaf_pkg::VOL_W-1:0]       vol_i,
  input  logic [cuaf_pkg::SUM_W-1:0]       sum_i,
  input  logic [cuaf_pkg::DIM_W-1:0]       dim_i,
  input  logic                             periodic_i,
  input  logic                             any_i,
  output logic signed [cuaf_pkg::CM_W-1:0] cm_o
);
  import cuaf_pkg::*;

  cuaf_d1_t  d1_q [Q1_W+1];
  cuaf_mid_t c_q, mul_q, wrap_q;
  cuaf_d2_t  d2_q [Q2_W+1];
  logic signed [CM_W-1:0] cm_q;

  // shift divider init, quotient saturates when sum >= vol * 2^Q1_W
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d1_q[0].lose <= lose_i;
      d1_q[0].raw  <= lose_i && (vol_i <= 20'd1);
      d1_q[0].pt   <= pt_i;
      d1_q[0].vol  <= vol_i;
      d1_q[0].sum  <= sum_i;
      d1_q[0].sat  <= {2'b0, sum_i[SUM_W-1:Q1_W]} >= vol_i;
      d1_q[0].rem  <= {2'b0, sum_i[SUM_W-1:Q1_W]};
      d1_q[0].quo  <= '0;
    end
  end

  for (genvar j = 1; j <= Q1_W; j++) begin : g_d1
    logic [VOL_W:0] remsh;
    logic           ge;
    cuaf_d1_t       nx;
    always_comb begin
      remsh = {d1_q[j-1].rem, d1_q[j-1].sum[Q1_W-j]};
      ge    = remsh >= {1'b0, d1_q[j-1].vol};
      nx    = d1_q[j-1];
      nx.rem = ge ? VOL_W'(remsh - {1'b0, d1_q[j-1].vol}) : remsh[VOL_W-1:0];
      nx.quo = {d1_q[j-1].quo[Q1_W-2:0], ge};
    end
    always_ff @(posedge clk_i) begin
      if (en_i[j]) d1_q[j] <= nx;
    end
  end

  // shift, point wrap and new sum
  cuaf_d1_t            a;
  logic [PT_W-1:0]     h;
  logic                doshift, adj, wp, wm, force_p;
  logic signed [13:0]  shift;
  logic signed [14:0]  tt, lim;
  logic signed [12:0]  off;
  cuaf_mid_t           c_d;

  always_comb begin
    a       = d1_q[Q1_W];
    h       = dim_i[DIM_W-1:1];
    doshift = periodic_i && (a.vol > 20'd1);
    adj     = (a.quo < {2'b0, h}) && (a.rem != '0);
    shift   = $signed({2'b0, a.quo}) - $signed({4'b0, h}) + $signed({13'b0, adj});
    tt      = doshift ? ($signed({5'b0, a.pt}) - $signed({shift[13], shift}))
                      : $signed({5'b0, a.pt});
    lim     = $signed({4'b0, dim_i}) - 15'sd1;
    force_p = doshift && a.sat;
    wp      = any_i && (force_p || (tt < 15'sd0));
    wm      = any_i && !force_p && !(tt < 15'sd0) && (tt > lim);
    off     = $signed({3'b0, a.pt});
    if (wp) off = off + $signed({2'b0, dim_i});
    if (wm) off = off - $signed({2'b0, dim_i});
    c_d.raw    = a.raw;
    c_d.rawval = (a.sum > 30'd1025) ? OUT_HI : {a.sum[11:0], 8'b0};
    c_d.c      = a.lose ? ($signed({2'b0, a.sum}) - $signed({{19{off[12]}}, off}))
                        : ($signed({2'b0, a.sum}) + $signed({{19{off[12]}}, off}));
    c_d.n      = a.lose ? ({1'b0, a.vol} - 21'd1) : ({1'b0, a.vol} + 21'd1);
    c_d.dn     = '0;
  end

  logic [31:0] prod;
  cuaf_mid_t   mul_d, wrap_d;

  always_comb begin
    prod     = {21'b0, dim_i} * {11'b0, c_q.n};
    mul_d    = c_q;
    mul_d.dn = prod[30:0];
    wrap_d   = mul_q;
    if (any_i && (mul_q.c < 32'sd0)) begin
      wrap_d.c = mul_q.c + $signed({1'b0, mul_q.dn});
    end else if (any_i && (mul_q.c > $signed({1'b0, mul_q.dn}))) begin
      wrap_d.c = mul_q.c - $signed({1'b0, mul_q.dn});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_C])    c_q    <= c_d;
    if (en_i[ST_MUL])  mul_q  <= mul_d;
    if (en_i[ST_WRAP]) wrap_q <= wrap_d;
  end

  // result divider init: numerator 512c + n, divisor 2n
  logic signed [41:0] nn, absn;
  cuaf_d2_t           n_d;

  always_comb begin
    nn  = $signed({wrap_q.c[31], wrap_q.c, 9'b0}) + $signed({21'b0, wrap_q.n});
    absn = nn[41] ? -nn : nn;
    n_d.raw    = wrap_q.raw;
    n_d.rawval = wrap_q.rawval;
    n_d.neg    = nn[41];
    n_d.d      = {wrap_q.n, 1'b0};
    n_d.mag    = absn[40:0];
    n_d.sat    = {1'b0, absn[40:Q2_W]} >= {wrap_q.n, 1'b0};
    n_d.rem    = {1'b0, absn[40:Q2_W]};
    n_d.quo    = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_N]) d2_q[0] <= n_d;
  end

  for (genvar j = 1; j <= Q2_W; j++) begin : g_d2
    logic [VOL_W+2:0] remsh;
    logic             ge;
    cuaf_d2_t         nx;
    always_comb begin
      remsh  = {d2_q[j-1].rem, d2_q[j-1].mag[Q2_W-j]};
      ge     = remsh >= {1'b0, d2_q[j-1].d};
      nx     = d2_q[j-1];
      nx.rem = ge ? (VOL_W+2)'(remsh - {1'b0, d2_q[j-1].d}) : remsh[VOL_W+1:0];
      nx.quo = {d2_q[j-1].quo[Q2_W-2:0], ge};
    end
    always_ff @(posedge clk_i) begin
      if (en_i[ST_N+j]) d2_q[j] <= nx;
    end
  end

  // floor for negative numerators, then clamp; raw items pass their raw value
  cuaf_d2_t           f;
  logic signed [21:0] val;
  logic signed [CM_W-1:0] cm_d;

  always_comb begin
    f   = d2_q[Q2_W];
    val = f.neg ? (-$signed({2'b0, f.quo}) - $signed({21'b0, (f.rem != '0)}))
                : $signed({2'b0, f.quo});
    if (f.raw) begin
      cm_d = f.rawval;
    end else if (f.sat) begin
      cm_d = f.neg ? OUT_LO : OUT_HI;
    end else if (val < $signed({{2{OUT_LO[CM_W-1]}}, OUT_LO})) begin
      cm_d = OUT_LO;
    end else if (val > $signed({2'b0, OUT_HI})) begin
      cm_d = OUT_HI;
    end else begin
      cm_d = val[CM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_OUT]) cm_q <= cm_d;
  end

  assign cm_o = cm_q;

endmodule

>>> rtl/core/centroid_update_after_flip_top.sv
// centroid_update_after_flip_top: config registers, stage valids, three axis pipelines
// depends on cuaf_pkg and cuaf_axis
//
// Takes one item per cycle while the output side does not stall. Each axis
// passes an item through two restoring dividers, one quotient bit per stage:
// 12 stages for the periodic shift (sum over volume) and 20 stages for the final
// fixed-point quotient, with the shift, multiply and wrap stages between them
// and the rounding stage after them. Empty stages close up under a stall, so
// items keep entering while a result waits at the output. Configuration writes
// take effect at once and are meant to happen only while the pipeline is empty.
module centroid_update_after_flip_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  cuaf_pkg::cuaf_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output cuaf_pkg::cuaf_out_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [cuaf_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cuaf_pkg::DIM_W-1:0]        cfg_wdata_i
);
  import cuaf_pkg::*;

  logic [DIM_W-1:0] dim_x_q, dim_y_q, dim_z_q;
  logic             per_x_q, per_y_q, per_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= DIM_RESET;
      dim_y_q <= DIM_RESET;
      dim_z_q <= DIMZ_RESET;
      per_x_q <= 1'b0;
      per_y_q <= 1'b0;
      per_z_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cuaf_reg_e'(cfg_idx_i))
        REG_DIM_X: dim_x_q <= cfg_wdata_i;
        REG_DIM_Y: dim_y_q <= cfg_wdata_i;
        REG_DIM_Z: dim_z_q <= cfg_wdata_i;
        REG_PER_X: per_x_q <= cfg_wdata_i[0];
        REG_PER_Y: per_y_q <= cfg_wdata_i[0];
        REG_PER_Z: per_z_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] eff_x, eff_y, eff_z;
  logic             any_per;

  assign eff_x   = (dim_x_q > DIM_MAX) ? DIM_MAX : dim_x_q;
  assign eff_y   = (dim_y_q > DIM_MAX) ? DIM_MAX : dim_y_q;
  assign eff_z   = (dim_z_q > DIM_MAX) ? DIM_MAX : dim_z_q;
  assign any_per = per_x_q | per_y_q | per_z_q;

  // a stage loads when it is empty or its contents move on
  logic [NSTAGE-1:0] vld_q, en;

  always_comb begin
    en[NSTAGE-1] = !vld_q[NSTAGE-1] || out_ready_i;
    for (int k = NSTAGE-2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NSTAGE-1];

  cuaf_axis u_axis_x (
    .clk_i, .en_i(en), .lose_i(in_data_i.operation), .pt_i(in_data_i.pt_x),
    .vol_i(in_data_i.volume), .sum_i(in_data_i.sum_x), .dim_i(eff_x),
    .periodic_i(per_x_q), .any_i(any_per), .cm_o(out_data_o.cm_x)
  );

  cuaf_axis u_axis_y (
    .clk_i, .en_i(en), .lose_i(in_data_i.operation), .pt_i(in_data_i.pt_y),
    .vol_i(in_data_i.volume), .sum_i(in_data_i.sum_y), .dim_i(eff_y),
    .periodic_i(per_y_q), .any_i(any_per), .cm_o(out_data_o.cm_y)
  );

  cuaf_axis u_axis_z (
    .clk_i, .en_i(en), .lose_i(in_data_i.operation), .pt_i(in_data_i.pt_z),
    .vol_i(in_data_i.volume), .sum_i(in_data_i.sum_z), .dim_i(eff_z),
    .periodic_i(per_z_q), .any_i(any_per), .cm_o(out_data_o.cm_z)
  );

endmodule

>>> rtl/core/cuaf_checker.sv
// cuaf_checker: port-level checks of the centroid pipeline, bound to the top level
// depends on cuaf_pkg
module cuaf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input cuaf_pkg::cuaf_in_t             in_data_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input cuaf_pkg::cuaf_out_t            out_data_o,
  input logic                           cfg_we_i,
  input logic [cuaf_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input logic [cuaf_pkg::DIM_W-1:0]     cfg_wdata_i
);
  import cuaf_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // an empty output stage never blocks the input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // no result is offered right after reset
  a_noinv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present out of reset");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.cm_x >= OUT_LO) && (out_data_o.cm_x <= OUT_HI) &&
                    (out_data_o.cm_y >= OUT_LO) && (out_data_o.cm_y <= OUT_HI) &&
                    (out_data_o.cm_z >= OUT_LO) && (out_data_o.cm_z <= OUT_HI))
    else $error("centroid outside clamp range");

endmodule

bind centroid_update_after_flip_top cuaf_checker u_cuaf_checker (.*);
